// ----- hw/rtl/rcfd_pkg.sv -----
// shared types and constants for the rc serial frame decoder
`default_nettype none

package rcfd_pkg;

	localparam logic [7:0] START_BYTE   = 8'h0f;
	localparam int         KEPT_BYTES   = 9;
	localparam int         BYTE_W       = 8;
	localparam int         CH_W         = 11;
	localparam int         THR_W        = 13;
	localparam int         OFS_W        = 12;
	localparam logic [OFS_W-1:0] OFFSET_RESET = 12'd300;
	localparam int         OUT_TDATA_W  = 72;

	// frame bytes 1 to 9, byte 1 in the lowest bits
	typedef logic [KEPT_BYTES*BYTE_W-1:0] frame_t;

	// one decoded result, roll in the lowest bits
	typedef struct packed {
		logic [CH_W-1:0]  mode_switch_value;
		logic [CH_W-1:0]  aux_value;
		logic [CH_W-1:0]  yaw_value;
		logic [THR_W-1:0] throttle_value;
		logic [CH_W-1:0]  pitch_value;
		logic [CH_W-1:0]  roll_value;
	} result_t;

	// handshake between queue and back end
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rcfd_front.sv -----
// front end: tracks the byte position, keeps channel bytes, pushes finished frames
`default_nettype none

module rcfd_front
	import rcfd_pkg::*;
#(
	parameter int FRAME_LENGTH = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        q_full,
	output logic             push,
	output frame_t           push_frame
);

	localparam int PosW = $clog2(FRAME_LENGTH + 1);

	logic [PosW-1:0]   pos_q;
	logic [BYTE_W-1:0] bytes_q [KEPT_BYTES];
	logic [BYTE_W-1:0] bytes_d [KEPT_BYTES];
	logic [PosW:0]     pos_sum;
	logic              accept;
	logic              is_start;
	logic              wrap;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_start = (in_byte == START_BYTE);
	assign pos_sum  = {1'b0, pos_q} + (PosW+1)'(1);
	assign wrap     = (pos_sum == (PosW+1)'(FRAME_LENGTH));

	// byte store with the incoming byte already applied
	always_comb begin
		for (int i = 0; i < KEPT_BYTES; i++) begin
			bytes_d[i] = bytes_q[i];
			if (!is_start && pos_q == PosW'(i + 1)) begin
				bytes_d[i] = in_byte;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < KEPT_BYTES; i++) begin
			push_frame[i*BYTE_W +: BYTE_W] = bytes_d[i];
		end
	end

	assign push = accept && !is_start && wrap;

	// channel byte registers
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < KEPT_BYTES; i++) begin
				bytes_q[i] <= bytes_d[i];
			end
		end
	end

	// position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				pos_q <= PosW'(1);
			end else if (wrap) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_sum[PosW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rcfd_queue.sv -----
// two-entry frame queue between front and back end
`default_nettype none

module rcfd_queue
	import rcfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  frame_t    push_frame,
	output logic      full,
	output hs_t       pop_hs_out,
	input  wire logic pop_ready,
	output frame_t    pop_frame
);

	frame_t      mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign full             = (count_q == 2'd2);
	assign pop_hs_out.valid = (count_q != 2'd0);
	assign pop_hs_out.ready = pop_ready;
	assign pop              = pop_hs_out.valid && pop_ready;
	assign pop_frame        = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rcfd_back.sv -----
// back end: unpacks channels, adds throttle offset, holds the output register
`default_nettype none

module rcfd_back
	import rcfd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  hs_t                   q_hs,
	output logic                  q_ready,
	input  frame_t                q_frame,
	input  wire logic             cfg_wr_en,
	input  wire logic [OFS_W-1:0] cfg_wr_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output result_t               out_result
);

	logic [OFS_W-1:0] offset_q;
	logic             valid_q;
	result_t          result_q;
	result_t          result_d;
	logic [CH_W-1:0]  ch [6];
	logic             take;

	assign q_ready = !valid_q || out_ready;
	assign take    = q_hs.valid && q_hs.ready;

	// channel k sits at bit 11k of the little-endian byte stream
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			ch[k] = q_frame[k*CH_W +: CH_W];
		end
	end

	always_comb begin
		result_d.roll_value        = ch[3];
		result_d.pitch_value       = ch[1];
		result_d.throttle_value    = THR_W'(ch[2]) + THR_W'(offset_q);
		result_d.yaw_value         = ch[0];
		result_d.aux_value         = ch[4];
		result_d.mode_switch_value = ch[5];
	end

	// throttle offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_ready) begin
			valid_q <= q_hs.valid;
		end
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rc_serial_frame_decoder.sv -----
// top level of the rc serial frame decoder
`default_nettype none

// Decodes an SBUS-style receiver byte stream, one byte per transaction. Byte 0x0f restarts
// the frame at position 1; every other byte is counted, and bytes 1 to 9 are kept. When the
// count reaches FRAME_LENGTH one result transaction carries roll, pitch, throttle (plus the
// throttle offset register, reset 300), yaw, aux and mode switch. The input takes one byte
// every cycle; it stalls only while the two-entry frame queue between the byte counter and
// the unpacking stage is full, which happens only if the output side holds off. A result
// appears in the cycle after it enters the unpacking stage, from a registered output.

module rc_serial_frame_decoder
	import rcfd_pkg::*;
#(
	parameter int FRAME_LENGTH = 25
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,  // rx_byte
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// roll[10:0] pitch[21:11] throttle[34:22] yaw[45:35] aux[56:46] mode_switch[67:57]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                   cfg_wr_en,
	input  wire logic [OFS_W-1:0]       cfg_wr_data
);

	logic    push;
	frame_t  push_frame;
	logic    q_full;
	hs_t     q_hs;
	logic    q_ready;
	frame_t  q_frame;
	result_t result;

	rcfd_front #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.q_full     (q_full),
		.push       (push),
		.push_frame (push_frame)
	);

	rcfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.full       (q_full),
		.pop_hs_out (q_hs),
		.pop_ready  (q_ready),
		.pop_frame  (q_frame)
	);

	rcfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_hs        (q_hs),
		.q_ready     (q_ready),
		.q_frame     (q_frame),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_result  (result)
	);

	// pad the result to whole bytes
	assign m_axis_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), result};

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for the rc serial frame decoder: byte stream in, decoded channel sets out
`default_nettype none

module tb_top
	import rcfd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN    = 25;
	localparam int TOTAL_BYTES  = 1700;
	localparam int PHASES       = 5;
	localparam int SETTLE       = 8;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int IDLE_PERCENT = 22;

	// predicts the decoded channel sets and checks the ones the block hands out
	class frame_decode_model;
		logic [4:0]       byte_pos;
		logic [7:0]       kept[KEPT_BYTES];
		logic [OFS_W-1:0] thr_offset;
		result_t          due_results[$];
		int               mismatches;

		function new();
			byte_pos   = '0;
			thr_offset = OFFSET_RESET;
			mismatches = 0;
			foreach (kept[i]) kept[i] = '0;
		endfunction

		function void set_offset(logic [OFS_W-1:0] v);
			thr_offset = v;
		endfunction

		// one accepted rx byte: update the frame position and maybe queue a channel set
		function void note_rx_byte(logic [7:0] b);
			logic [KEPT_BYTES*BYTE_W-1:0] bits;
			logic [4:0]                   nxt;
			result_t                      r;
			if (b == START_BYTE) begin
				byte_pos = 5'd1;
				return;
			end
			if (byte_pos >= 1 && byte_pos <= KEPT_BYTES) begin
				kept[byte_pos-1] = b;
			end
			nxt = byte_pos + 5'd1;
			if (nxt != FRAME_LEN) begin
				byte_pos = nxt;
				return;
			end
			byte_pos = '0;
			for (int i = 0; i < KEPT_BYTES; i++) begin
				bits[i*BYTE_W +: BYTE_W] = kept[i];
			end
			// channels are packed little-endian, 11 bits each, from bit 0 of byte 1
			r.yaw_value         = bits[0*CH_W +: CH_W];
			r.pitch_value       = bits[1*CH_W +: CH_W];
			r.throttle_value    = THR_W'(bits[2*CH_W +: CH_W]) + THR_W'(thr_offset);
			r.roll_value        = bits[3*CH_W +: CH_W];
			r.aux_value         = bits[4*CH_W +: CH_W];
			r.mode_switch_value = bits[5*CH_W +: CH_W];
			due_results.push_back(r);
		endfunction

		function void check_field(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
				mismatches++;
			end
		endfunction

		// one result transaction against the oldest expected channel set
		function void check_result(result_t got);
			result_t exp_r;
			if (due_results.size() == 0) begin
				$error("result transaction with no channel set expected");
				mismatches++;
				return;
			end
			exp_r = due_results.pop_front();
			check_field("roll_value", exp_r.roll_value, got.roll_value);
			check_field("pitch_value", exp_r.pitch_value, got.pitch_value);
			check_field("throttle_value", exp_r.throttle_value, got.throttle_value);
			check_field("yaw_value", exp_r.yaw_value, got.yaw_value);
			check_field("aux_value", exp_r.aux_value, got.aux_value);
			check_field("mode_switch_value", exp_r.mode_switch_value,
				got.mode_switch_value);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [OFS_W-1:0]       cfg_wr_data = '0;

	frame_decode_model decoder_model = new();
	bit                calm = 1'b0;
	int                bytes_sent = 0;

	rc_serial_frame_decoder #(
		.FRAME_LENGTH(FRAME_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// result side: check each transaction, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				decoder_model.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
			end
			m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// one byte transaction, with idle cycles before it at random
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		decoder_model.note_rx_byte(b);
		bytes_sent++;
	endtask

	// wait until every expected channel set is out, then let the pipeline settle
	task automatic wait_drained();
		int n;
		n = 0;
		s_axis_tvalid <= 1'b0;
		while (decoder_model.due_results.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (decoder_model.due_results.size() != 0) begin
			$error("%0d channel sets never came out", decoder_model.due_results.size());
			decoder_model.mismatches += decoder_model.due_results.size();
			decoder_model.due_results.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_offset(input logic [OFS_W-1:0] v);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		decoder_model.set_offset(v);
	endtask

	// frame content byte: never the start byte, sometimes all zeros or all ones
	function automatic logic [7:0] content_byte();
		logic [7:0] v;
		case ($urandom_range(0, 19))
			0: v = 8'h00;
			1: v = 8'hff;
			default: begin
				do v = 8'($urandom_range(0, 255)); while (v == START_BYTE);
			end
		endcase
		return v;
	endfunction

	// one random stretch of stream: mostly whole frames, some broken ones and noise
	task automatic send_random_stretch();
		int pick;
		int cut;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			send_byte(START_BYTE);
			repeat (FRAME_LEN - 1) send_byte(content_byte());
		end else if (pick < 80) begin
			// frame with a plain byte in place of the start byte
			repeat (FRAME_LEN) send_byte(content_byte());
		end else if (pick < 90) begin
			// frame cut short by a restart
			cut = $urandom_range(1, FRAME_LEN - 2);
			send_byte(START_BYTE);
			repeat (cut) send_byte(content_byte());
			send_byte(START_BYTE);
		end else begin
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 7) == 0) send_byte(START_BYTE);
				else send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// main sequence
	initial begin
		logic [OFS_W-1:0] phase_offset[PHASES];
		int               phase_end;
		phase_offset[0] = '0;
		phase_offset[1] = 12'($urandom_range(1, 4094));
		phase_offset[2] = '1;
		phase_offset[3] = OFFSET_RESET;
		phase_offset[4] = 12'($urandom_range(0, 4095));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// largest throttle: all-ones channels with the largest offset
		write_offset('1);
		send_byte(START_BYTE);
		send_byte(8'h55);
		send_byte(START_BYTE);
		repeat (FRAME_LEN - 1) send_byte(8'hff);

		for (int p = 0; p < PHASES; p++) begin
			write_offset(phase_offset[p]);
			calm      = (p == 2);
			phase_end = (TOTAL_BYTES * (p + 1)) / PHASES;
			while (bytes_sent < phase_end) send_random_stretch();
		end
		wait_drained();
		calm = 1'b0;

		if (decoder_model.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// run time limit
	initial begin
		#3ms;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/rcfd_pkg.sv
hw/rtl/rcfd_front.sv
hw/rtl/rcfd_queue.sv
hw/rtl/rcfd_back.sv
hw/rtl/rc_serial_frame_decoder.sv
tb/sv/tb_top.sv
